/* hw/rtl/lzwd_pkg.sv */
// shared types and constants for the 12-bit lzw decoder
package lzwd_pkg;

    localparam int CODE_W       = 12;
    localparam int BYTE_W       = 8;
    localparam int LEN_W        = 7;
    localparam int NUM_LITERALS = 256;
    localparam int DICT_SIZE_DEF = 4096;
    localparam int MAX_LEN_DEF   = 64;

    // one dictionary entry: prefix code, appended byte, first byte of the string, length
    typedef struct packed {
        logic [CODE_W-1:0] prefix;
        logic [BYTE_W-1:0] suffix;
        logic [BYTE_W-1:0] first;
        logic [LEN_W-1:0]  len;
    } dict_entry_t;

    // command from the dictionary walker to the output unit
    typedef struct packed {
        logic             start;
        logic             bad;
        logic [LEN_W-1:0] len;
    } emit_cmd_t;

endpackage

/* hw/rtl/lzwd_emit.sv */
// string stack and output stage: replays a decoded string first byte first
module lzwd_emit #(
    parameter int MAX_LEN = lzwd_pkg::MAX_LEN_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  lzwd_pkg::emit_cmd_t               cmd,
    input  logic                              st_we,
    input  logic [$clog2(MAX_LEN)-1:0]        st_addr,
    input  logic [lzwd_pkg::BYTE_W-1:0]       st_data,
    output logic                              busy,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lzwd_pkg::BYTE_W-1:0]       m_data_byte,
    output logic                              m_last_byte,
    output logic                              m_bad_code
);
    import lzwd_pkg::*;

    localparam int SP_W = $clog2(MAX_LEN);

    logic [BYTE_W-1:0] stack_mem [MAX_LEN];
    logic [BYTE_W-1:0] q_reg;

    logic              q_valid_reg, q_valid_next;
    logic              q_last_reg, q_last_next;
    logic [LEN_W-1:0]  em_idx_reg, em_idx_next;
    logic [LEN_W-1:0]  em_len_reg, em_len_next;
    logic              bad_pend_reg, bad_pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0] m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;
    logic              m_bad_reg, m_bad_next;

    logic out_free;
    logic load_out;
    logic issue;

    // stack memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (st_we) begin
            stack_mem[st_addr] <= st_data;
        end
        if (issue) begin
            q_reg <= stack_mem[em_idx_reg[SP_W-1:0]];
        end
    end

    // read scheduling: one byte per cycle while the output stage drains
    always_comb begin
        out_free = !m_valid_reg || m_ready;
        load_out = q_valid_reg && out_free;
        issue    = (em_idx_reg != em_len_reg) && (!q_valid_reg || load_out);

        q_valid_next  = q_valid_reg;
        q_last_next   = q_last_reg;
        em_idx_next   = em_idx_reg;
        em_len_next   = em_len_reg;
        bad_pend_next = bad_pend_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_bad_next    = m_bad_reg;

        if (issue) begin
            q_valid_next = 1'b1;
            q_last_next  = (em_idx_reg + LEN_W'(1)) == em_len_reg;
            em_idx_next  = em_idx_reg + LEN_W'(1);
        end else if (load_out) begin
            q_valid_next = 1'b0;
        end

        // output register
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = q_reg;
            m_last_next  = q_last_reg;
            m_bad_next   = 1'b0;
        end else if (bad_pend_reg && out_free) begin
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_last_next   = 1'b0;
            m_bad_next    = 1'b1;
            bad_pend_next = 1'b0;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        // new string or error beat
        if (cmd.start) begin
            if (cmd.bad) begin
                bad_pend_next = 1'b1;
            end else begin
                em_idx_next = '0;
                em_len_next = cmd.len;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg  <= 1'b0;
            em_idx_reg   <= '0;
            em_len_reg   <= '0;
            bad_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            q_valid_reg  <= q_valid_next;
            em_idx_reg   <= em_idx_next;
            em_len_reg   <= em_len_next;
            bad_pend_reg <= bad_pend_next;
            m_valid_reg  <= m_valid_next;
        end
        q_last_reg <= q_last_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_bad_reg  <= m_bad_next;
    end

    assign busy        = (em_idx_reg != em_len_reg) || q_valid_reg || bad_pend_reg;
    assign m_valid     = m_valid_reg;
    assign m_data_byte = m_data_reg;
    assign m_last_byte = m_last_reg;
    assign m_bad_code  = m_bad_reg;

endmodule

/* hw/rtl/lzw_decoder_12bit_core.sv */
// top level of the 12-bit lzw decoder: dictionary memory, chain walker and output unit
//
// The decoder takes one 12-bit code per input beat and returns the bytes of its string, one
// beat per byte, first byte first, with m_last_byte on the final byte. A rejected code gives a
// single beat with m_bad_code set. For each code the idle state takes the code, the lookup
// state looks it up and the prep state re-reads it; the walk state then follows the prefix
// chain through the single-port-read dictionary memory (one entry per cycle), and the output
// unit replays the string from the stack memory at one byte per cycle while the output
// accepts it, until the last read reaches the output register and the output unit goes idle.
// Output stalls lengthen the replay. The next code is taken once the previous string has left
// the stack; the last byte may still sit in the output register. The dictionary needs no
// clearing after reset.
module lzw_decoder_12bit_core #(
    parameter int DICT_SIZE = lzwd_pkg::DICT_SIZE_DEF,
    parameter int MAX_LEN   = lzwd_pkg::MAX_LEN_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [lzwd_pkg::CODE_W-1:0]   s_code,
    input  logic                          s_start_req,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lzwd_pkg::BYTE_W-1:0]   m_data_byte,
    output logic                          m_last_byte,
    output logic                          m_bad_code
);
    import lzwd_pkg::*;

    localparam int MEM_DEPTH = (DICT_SIZE < (1 << CODE_W)) ? DICT_SIZE : (1 << CODE_W);
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int NF_W      = $clog2(DICT_SIZE) + 1;
    localparam int CMP_W     = (NF_W > CODE_W) ? NF_W : CODE_W;
    localparam int SP_W      = $clog2(MAX_LEN);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOOKUP = 3'd1;
    localparam logic [2:0] ST_PREP   = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;

    dict_entry_t dict_mem [MEM_DEPTH];
    dict_entry_t dict_q;
    logic        dict_we;
    logic [AW-1:0] dict_waddr;
    dict_entry_t dict_wdata;
    logic        dict_re;
    logic [AW-1:0] dict_raddr;

    logic [2:0]        state_reg, state_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic              start_reg, start_next;
    logic [NF_W-1:0]   next_free_reg, next_free_next;
    logic [CODE_W-1:0] prev_code_reg, prev_code_next;
    logic [LEN_W-1:0]  prev_len_reg, prev_len_next;
    logic [BYTE_W-1:0] prev_first_reg, prev_first_next;
    logic              started_reg, started_next;
    logic [CODE_W-1:0] cur_reg, cur_next;
    logic [SP_W-1:0]   pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    emit_cmd_t         cmd;
    logic              st_we;
    logic [SP_W-1:0]   st_addr;
    logic [BYTE_W-1:0] st_data;
    logic              emit_busy;

    logic              first_code;
    logic              code_lit;
    logic              code_gt;
    logic              kwkwk;
    logic              room;
    logic [BYTE_W-1:0] cur_first;
    logic [LEN_W-1:0]  cur_len;
    logic [LEN_W-1:0]  len_m1;
    logic              cur_lit;

    // dictionary memory, one write and one registered read
    always_ff @(posedge aclk) begin
        if (dict_we) begin
            dict_mem[dict_waddr] <= dict_wdata;
        end
        if (dict_re) begin
            dict_q <= dict_mem[dict_raddr];
        end
    end

    // decode of the looked-up code
    always_comb begin
        first_code = start_reg || !started_reg;
        code_lit   = code_reg < CODE_W'(NUM_LITERALS);
        code_gt    = CMP_W'(code_reg) > CMP_W'(next_free_reg);
        kwkwk      = CMP_W'(code_reg) == CMP_W'(next_free_reg);
        room       = (next_free_reg < NF_W'(DICT_SIZE)) && (prev_len_reg < LEN_W'(MAX_LEN));
        if (code_lit) begin
            cur_first = code_reg[BYTE_W-1:0];
            cur_len   = LEN_W'(1);
        end else if (kwkwk) begin
            cur_first = prev_first_reg;
            cur_len   = prev_len_reg + LEN_W'(1);
        end else begin
            cur_first = dict_q.first;
            cur_len   = dict_q.len;
        end
        len_m1  = len_reg - LEN_W'(1);
        cur_lit = cur_reg < CODE_W'(NUM_LITERALS);
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        code_next       = code_reg;
        start_next      = start_reg;
        next_free_next  = next_free_reg;
        prev_code_next  = prev_code_reg;
        prev_len_next   = prev_len_reg;
        prev_first_next = prev_first_reg;
        started_next    = started_reg;
        cur_next        = cur_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;

        s_ready    = 1'b0;
        dict_we    = 1'b0;
        dict_waddr = next_free_reg[AW-1:0];
        dict_wdata.prefix = prev_code_reg;
        dict_wdata.suffix = cur_first;
        dict_wdata.first  = prev_first_reg;
        dict_wdata.len    = prev_len_reg + LEN_W'(1);
        dict_re    = 1'b0;
        dict_raddr = code_reg[AW-1:0];
        cmd        = '0;
        st_we      = 1'b0;
        st_addr    = pos_reg;
        st_data    = cur_lit ? cur_reg[BYTE_W-1:0] : dict_q.suffix;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                dict_raddr = s_code[AW-1:0];
                if (s_valid) begin
                    dict_re    = 1'b1;
                    code_next  = s_code;
                    start_next = s_start_req;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (first_code) begin
                    next_free_next = NF_W'(NUM_LITERALS);
                    if (!code_lit) begin
                        started_next = 1'b0;
                        cmd.start    = 1'b1;
                        cmd.bad      = 1'b1;
                        state_next   = ST_DRAIN;
                    end else begin
                        started_next    = 1'b1;
                        prev_code_next  = code_reg;
                        prev_len_next   = LEN_W'(1);
                        prev_first_next = code_reg[BYTE_W-1:0];
                        len_next        = LEN_W'(1);
                        state_next      = ST_PREP;
                    end
                end else if (code_gt || (kwkwk && !room)) begin
                    cmd.start  = 1'b1;
                    cmd.bad    = 1'b1;
                    state_next = ST_DRAIN;
                end else begin
                    // new entry: previous string plus first byte of this one
                    if (room) begin
                        dict_we        = next_free_reg < NF_W'(MEM_DEPTH);
                        next_free_next = next_free_reg + NF_W'(1);
                    end
                    prev_code_next  = code_reg;
                    prev_len_next   = cur_len;
                    prev_first_next = cur_first;
                    len_next        = cur_len;
                    state_next      = ST_PREP;
                end
            end
            ST_PREP: begin
                // re-read so a just-written entry is seen
                dict_re    = 1'b1;
                cur_next   = code_reg;
                pos_next   = len_m1[SP_W-1:0];
                state_next = ST_WALK;
            end
            ST_WALK: begin
                // push one byte per cycle, last byte at the top position
                st_we = 1'b1;
                if (cur_lit || (pos_reg == '0)) begin
                    cmd.start  = 1'b1;
                    cmd.len    = len_reg;
                    state_next = ST_DRAIN;
                end else begin
                    dict_re    = 1'b1;
                    dict_raddr = dict_q.prefix[AW-1:0];
                    cur_next   = dict_q.prefix;
                    pos_next   = pos_reg - SP_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!emit_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            next_free_reg <= NF_W'(NUM_LITERALS);
            prev_code_reg <= '0;
            started_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            prev_code_reg <= prev_code_next;
            started_reg   <= started_next;
        end
        code_reg       <= code_next;
        start_reg      <= start_next;
        prev_len_reg   <= prev_len_next;
        prev_first_reg <= prev_first_next;
        cur_reg        <= cur_next;
        pos_reg        <= pos_next;
        len_reg        <= len_next;
    end

    // string stack and result beats
    lzwd_emit #(
        .MAX_LEN (MAX_LEN)
    ) u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .st_we       (st_we),
        .st_addr     (st_addr),
        .st_data     (st_data),
        .busy        (emit_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_last_byte (m_last_byte),
        .m_bad_code  (m_bad_code)
    );

endmodule

/* tb/sv/lzw_decoder_12bit_core_tb.sv */
// self-checking testbench for the 12-bit lzw decoder core
module lzw_decoder_12bit_core_tb;
    import lzwd_pkg::*;

    localparam int DICT_ENTRIES = DICT_SIZE_DEF;
    localparam int MAX_STR      = MAX_LEN_DEF;
    localparam int LITERALS     = NUM_LITERALS;
    localparam int TOP_CODE     = (1 << CODE_W) - 1;
    localparam int RANDOM_CODES = 220;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 1000000;

    // one expected output beat
    typedef struct packed {
        logic [BYTE_W-1:0] byte_val;
        logic              is_last;
        logic              is_bad;
    } byte_beat_t;

    // decoder state copy plus the queue of bytes still to come
    class lzw_scoreboard;
        logic [CODE_W-1:0] prefix_mem [DICT_ENTRIES];
        logic [BYTE_W-1:0] suffix_mem [DICT_ENTRIES];
        int                len_mem    [DICT_ENTRIES];
        int                next_free;
        int                prev_code;
        bit                started;
        byte_beat_t        byte_q[$];
        int                errors;
        int                codes_seen;
        int                bytes_checked;
        int                rejects;
        int                longest;

        function new();
            next_free = LITERALS;
            prev_code = 0;
            started   = 1'b0;
        endfunction

        function int str_length(int c);
            if (c < LITERALS) return 1;
            return len_mem[c];
        endfunction

        // follow the prefix chain down to the literal
        function logic [BYTE_W-1:0] lead_byte(int c);
            int n;
            for (n = 0; n < MAX_STR && c >= LITERALS; n++) c = int'(prefix_mem[c]);
            return c[BYTE_W-1:0];
        endfunction

        function void queue_reject();
            byte_beat_t b;
            b = '{byte_val: '0, is_last: 1'b0, is_bad: 1'b1};
            byte_q.insert(byte_q.size(), b);
            rejects++;
        endfunction

        // collect the string backwards, then queue it first byte first
        function void queue_string(int c);
            logic [BYTE_W-1:0] stack_b [MAX_STR];
            byte_beat_t b;
            int n;
            int k;
            n = 0;
            while (n < MAX_STR) begin
                if (c < LITERALS) begin
                    stack_b[n] = c[BYTE_W-1:0];
                    n++;
                    break;
                end
                stack_b[n] = suffix_mem[c];
                n++;
                c = int'(prefix_mem[c]);
            end
            for (k = n - 1; k >= 0; k--) begin
                b = '{byte_val: stack_b[k], is_last: (k == 0), is_bad: 1'b0};
                byte_q.insert(byte_q.size(), b);
            end
            if (n > longest) longest = n;
        endfunction

        // note one accepted code and predict its bytes
        function void note_code(logic [CODE_W-1:0] code, bit restart);
            int  c;
            int  plen;
            bit  room;
            logic [BYTE_W-1:0] fb;
            c = int'(code);
            codes_seen++;
            // first code of a stream
            if (restart || !started) begin
                next_free = LITERALS;
                started   = 1'b0;
                if (c >= LITERALS) begin
                    queue_reject();
                    return;
                end
                started   = 1'b1;
                prev_code = c;
                queue_string(c);
                return;
            end
            if (c > next_free) begin
                queue_reject();
                return;
            end
            plen = str_length(prev_code);
            room = (next_free < DICT_ENTRIES) && (plen < MAX_STR);
            // kwkwk takes the first byte of the previous string
            if (c == next_free) begin
                if (!room) begin
                    queue_reject();
                    return;
                end
                fb = lead_byte(prev_code);
            end else begin
                fb = lead_byte(c);
            end
            if (room) begin
                prefix_mem[next_free] = prev_code[CODE_W-1:0];
                suffix_mem[next_free] = fb;
                len_mem[next_free]    = plen + 1;
                next_free++;
            end
            prev_code = c;
            queue_string(c);
        endfunction

        // compare one output beat with the oldest expected one
        function void check_byte(logic [BYTE_W-1:0] data, logic last, logic bad);
            byte_beat_t exp_b;
            if (byte_q.size() == 0) begin
                $display("%0t: unexpected beat, got data %02h last %0b bad %0b",
                         $time, data, last, bad);
                errors++;
                return;
            end
            exp_b = byte_q.pop_front();
            bytes_checked++;
            if (data !== exp_b.byte_val || last !== exp_b.is_last || bad !== exp_b.is_bad) begin
                $display("%0t: beat mismatch, expected data %02h last %0b bad %0b, ",
                         $time, exp_b.byte_val, exp_b.is_last, exp_b.is_bad,
                         "got data %02h last %0b bad %0b", data, last, bad);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [CODE_W-1:0] s_code = '0;
    logic              s_start_req = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_data_byte;
    logic              m_last_byte;
    logic              m_bad_code;

    lzw_scoreboard sb;
    int burst_left  = 0;
    int codes_sent  = 0;
    int cycle_count = 0;
    int rx_mode     = 0;
    int rx_span     = 0;
    int rx_hold     = 0;
    int rx_tick     = 0;

    lzw_decoder_12bit_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_code      (s_code),
        .s_start_req (s_start_req),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_byte (m_data_byte),
        .m_last_byte (m_last_byte),
        .m_bad_code  (m_bad_code)
    );

    always #6 aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver backpressure: a random mode, redrawn after a random span
    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_span = $urandom_range(20, 200);
        end
        rx_span--;
        rx_tick++;
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (rx_tick % 5) != 0;
            default: begin
                if (rx_hold > 0) begin
                    rx_hold--;
                    m_ready <= 1'b0;
                end else if ($urandom_range(0, 9) == 0) begin
                    rx_hold = $urandom_range(2, 8);
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    // output beat monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_byte(m_data_byte, m_last_byte, m_bad_code);
    end

    // present one code, with bursts and gaps on the input side
    task automatic send_code(input logic [CODE_W-1:0] c, input bit restart);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_code      <= c;
        s_start_req <= restart;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_code(c, restart);
        codes_sent++;
    endtask

    function automatic logic [CODE_W-1:0] known_code();
        if (sb.next_free > LITERALS && $urandom_range(0, 9) < 7)
            return CODE_W'($urandom_range(LITERALS, sb.next_free - 1));
        return CODE_W'($urandom_range(0, LITERALS - 1));
    endfunction

    // next free index, or a literal once the dictionary is full
    function automatic logic [CODE_W-1:0] kwkwk_code();
        if (sb.next_free < DICT_ENTRIES) return CODE_W'(sb.next_free);
        return CODE_W'($urandom_range(0, LITERALS - 1));
    endfunction

    // well-formed stream with random content and a few rejects
    task automatic run_stream(input int n);
        int k;
        int r;
        logic [CODE_W-1:0] c;
        send_code(CODE_W'($urandom_range(0, LITERALS - 1)), 1'b1);
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 10) c = kwkwk_code();
            else if (r < 14 && sb.next_free < TOP_CODE)
                c = CODE_W'($urandom_range(sb.next_free + 1, TOP_CODE));
            else c = known_code();
            send_code(c, 1'b0);
        end
    endtask

    // repeated kwkwk codes grow the string by one byte each
    task automatic run_chain(input int n, input bit restart);
        int k;
        if (restart || !sb.started) send_code(CODE_W'($urandom_range(0, LITERALS - 1)), 1'b1);
        for (k = 0; k < n; k++) send_code(kwkwk_code(), 1'b0);
    endtask

    initial begin
        int k;
        int base;
        int pick;
        sb = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: first code without start, kwkwk, rejects, restarts
        send_code(12'h041, 1'b0);
        send_code(12'h0FF, 1'b0);
        send_code(12'h100, 1'b0);
        send_code(12'h102, 1'b0);
        send_code(12'hFFF, 1'b0);
        send_code(12'h104, 1'b0);
        send_code(12'h103, 1'b0);
        send_code(12'h000, 1'b1);
        send_code(12'hFFF, 1'b1);
        send_code(12'h12C, 1'b0);
        send_code(12'h000, 1'b0);
        send_code(12'h100, 1'b0);
        send_code(12'h100, 1'b0);
        send_code(12'h101, 1'b0);
        send_code(12'h800, 1'b1);
        send_code(12'h0AA, 1'b0);
        send_code(12'h055, 1'b0);
        send_code(12'h100, 1'b0);
        send_code(12'h0FF, 1'b1);
        send_code(12'h100, 1'b0);

        // longest string, kwkwk with no room, overlong previous string
        run_chain(MAX_STR, 1'b1);
        send_code(CODE_W'($urandom_range(0, LITERALS - 1)), 1'b0);
        send_code(CODE_W'(sb.next_free - 1), 1'b0);

        // random mix of streams, chains, noise and broken starts
        base = codes_sent;
        while (codes_sent - base < RANDOM_CODES) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                run_stream($urandom_range(4, 30));
            end else if (pick < 8) begin
                if ($urandom_range(0, 9) == 0) run_chain(MAX_STR + 2, 1'b1);
                else run_chain($urandom_range(2, 12), 1'b0);
            end else if (pick == 8) begin
                for (k = $urandom_range(1, 6); k > 0; k--)
                    send_code(CODE_W'($urandom_range(0, TOP_CODE)), $urandom_range(0, 3) == 0);
            end else begin
                send_code(CODE_W'($urandom_range(LITERALS, TOP_CODE)), 1'b1);
                send_code(CODE_W'($urandom_range(0, TOP_CODE)), $urandom_range(0, 1) == 1);
            end
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // drain
        while (sb.byte_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d codes, %0d output beats, %0d rejected codes",
                 sb.codes_seen, sb.bytes_checked, sb.rejects);
        $display("strings up to %0d bytes, kwkwk chains, restarts and broken stream starts",
                 sb.longest);
        if (sb.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lzwd_pkg.sv
hw/rtl/lzwd_emit.sv
hw/rtl/lzw_decoder_12bit_core.sv
tb/sv/lzw_decoder_12bit_core_tb.sv
